>>> hw/rtl/wmst_pkg.sv
// Shared constants and types for the window-mean score trigger.
`timescale 1ns / 1ps
package wmst_pkg;

	// Sizes
	localparam int MAX_WINDOW = 8192;
	localparam int HIST_AW    = $clog2(MAX_WINDOW);
	localparam int PRICE_W    = 32;
	localparam int SUM_W      = 45;
	localparam int LEN_W      = 14;
	localparam int GAIN_W     = 16;
	localparam int LEVEL_W    = 31;
	localparam int SCORE_W    = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_DROP  = 14;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 2'd3;

	// Register reset values
	localparam logic [LEN_W-1:0]          RST_WINDOW_LEN    = 14'd6947;
	localparam logic signed [GAIN_W-1:0]  RST_MEAN_GAIN     = -16'sd2770;
	localparam logic signed [GAIN_W-1:0]  RST_MOMENTUM_GAIN = 16'sd1017;
	localparam logic [LEVEL_W-1:0]        RST_TRIGGER_LEVEL = 31'd219;

	// Order direction
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/wmst_if.sv
// Channel interfaces: price samples in, triggers out, register writes.
`timescale 1ns / 1ps
interface wmst_price_if;
	logic        valid;
	logic        ready;
	logic [31:0] price;
	modport source (output valid, price, input ready);
	modport sink   (input valid, price, output ready);
endinterface

interface wmst_trig_if;
	logic               valid;
	logic               ready;
	logic               side;
	logic signed [63:0] score;
	modport source (output valid, side, score, input ready);
	modport sink   (input valid, side, score, output ready);
endinterface

interface wmst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wmst_hist_ram.sv
// Price history memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module wmst_hist_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [wmst_pkg::HIST_AW-1:0] waddr,
	input  logic [wmst_pkg::PRICE_W-1:0] wdata,
	input  logic [wmst_pkg::HIST_AW-1:0] raddr,
	output logic [wmst_pkg::PRICE_W-1:0] rdata
);
	import wmst_pkg::*;

	logic [PRICE_W-1:0] mem [MAX_WINDOW];
	logic [PRICE_W-1:0] rdata_q;

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/wmst_div.sv
// Bit-serial restoring divider: window sum by window length, one bit a cycle.
`timescale 1ns / 1ps
module wmst_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wmst_pkg::div_req_t req,
	output wmst_pkg::div_rsp_t rsp
);
	import wmst_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     dvsr_q;
	logic [LEN_W-1:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [LEN_W:0]       shifted;
	logic [LEN_W:0]       diff;
	logic                 qbit;

	// One trial subtraction per step
	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		diff    = shifted - {1'b0, dvsr_q};
		qbit    = (shifted >= {1'b0, dvsr_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: dividend shifts out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvsr_q <= req.divisor;
			rem_q  <= '0;
			quo_q  <= req.dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

>>> hw/rtl/window_mean_score_trigger_core.sv
// Window-mean score trigger: top level with the per-sample sequencer.
//
// Usage: price samples enter on the sample channel (valid/ready), one item
// per price. Register writes arrive on the cfg channel, which is always
// ready: index 0 window length, 1 mean gain, 2 momentum gain, 3 trigger
// level. Writing the window length empties the window and restarts warm-up;
// the position flag is kept. Write registers only while the block is idle.
// Triggers leave on the trigger channel: side (0 buy, 1 sell) and the score.
// A warm-up sample leaves the block idle, ready for the next sample. A
// sample on a full window goes through accept, history read, the bit-serial
// divider for the 45-bit sum, multiply, sum/round and decide, and no new
// sample is taken until it is done. The trigger is registered from decide.
// The trigger sits in an output register; the block takes the next sample
// while it waits, and stalls in the decide step only if a second trigger is
// due before the first is taken.
// Reset: registers return to their defaults, the window is empty and the
// position is flat. The history memory needs no clearing; it is read only
// at entries written since the window was last emptied.
`timescale 1ns / 1ps
module window_mean_score_trigger_core (
	input  logic clk,
	input  logic arst_n,
	wmst_price_if.sink   sample,
	wmst_cfg_if.sink     cfg,
	wmst_trig_if.source  trigger
);
	import wmst_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_DEC  = 3'd5;

	localparam logic signed [49:0] ROUND_HALF = 50'sd1 <<< (FRAC_DROP - 1);

	// Registers
	logic [2:0]                state_q;
	logic [LEN_W-1:0]          window_len_q;
	logic signed [GAIN_W-1:0]  mean_gain_q;
	logic signed [GAIN_W-1:0]  momentum_gain_q;
	logic [LEVEL_W-1:0]        level_q;
	logic [SUM_W-1:0]          sum_q;
	logic [LEN_W-1:0]          fill_q;
	logic [HIST_AW-1:0]        slot_q;
	logic                      holding_q;
	logic [PRICE_W-1:0]        price_q;
	logic                      fwd_q;
	logic [PRICE_W-1:0]        oldest_q;
	logic [PRICE_W-1:0]        mean_q;
	logic signed [48:0]        prod0_q;
	logic signed [48:0]        prod1_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      out_valid_q;
	logic                      out_side_q;
	logic signed [SCORE_W-1:0] out_score_q;

	// Combinational
	logic [LEN_W-1:0]          eff_len;
	logic [LEN_W-1:0]          cnt;
	logic                      accept;
	logic                      cfg_wr;
	logic [PRICE_W-1:0]        ram_rdata;
	logic [PRICE_W-1:0]        oldest;
	logic signed [32:0]        d0;
	logic signed [32:0]        d1;
	logic signed [48:0]        prod0;
	logic signed [48:0]        prod1;
	logic signed [49:0]        total;
	logic signed [SCORE_W-1:0] level_pos;
	logic signed [SCORE_W-1:0] level_neg;
	logic                      fire;
	logic                      out_free;
	logic                      out_load;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	// Window length clamp: zero acts as one, above the history depth as the depth
	always_comb begin
		if (window_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (window_len_q > LEN_W'(MAX_WINDOW)) begin
			eff_len = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = window_len_q;
		end
	end

	assign accept    = sample.valid && sample.ready;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cnt       = fill_q + 1'b1;
	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// History memory; oldest entry sits fill_q slots behind the write slot
	wmst_hist_ram u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (slot_q),
		.wdata (sample.price),
		.raddr (slot_q - fill_q[HIST_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Window of one: the oldest sample is the one just written
	assign oldest = fwd_q ? price_q : ram_rdata;

	// Mean divider
	assign div_req.start    = (state_q == ST_READ);
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = eff_len;

	wmst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Score arithmetic
	always_comb begin
		d0        = $signed({1'b0, price_q}) - $signed({1'b0, mean_q});
		d1        = $signed({1'b0, price_q}) - $signed({1'b0, oldest_q});
		prod0     = mean_gain_q * d0;
		prod1     = momentum_gain_q * d1;
		total     = 50'(prod0_q) + 50'(prod1_q) + ROUND_HALF;
		level_pos = $signed({{(SCORE_W-LEVEL_W){1'b0}}, level_q});
		level_neg = -level_pos;
		fire      = holding_q ? (score_q < level_neg) : (score_q > level_pos);
		out_free  = !out_valid_q || trigger.ready;
		out_load  = (state_q == ST_DEC) && fire && out_free;
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_len_q    <= RST_WINDOW_LEN;
			mean_gain_q     <= RST_MEAN_GAIN;
			momentum_gain_q <= RST_MOMENTUM_GAIN;
			level_q         <= RST_TRIGGER_LEVEL;
			sum_q           <= '0;
			fill_q          <= '0;
			slot_q          <= '0;
			holding_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sum_q  <= sum_q + SUM_W'(sample.price);
						slot_q <= slot_q + 1'b1;
						if (cnt < eff_len) begin
							fill_q <= cnt;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// divider has taken the sum; retire the oldest sample
					sum_q   <= sum_q - SUM_W'(oldest);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!fire) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						holding_q <= !holding_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes
			if (cfg_wr) begin
				case (cfg.index)
					REG_WINDOW_LEN: begin
						window_len_q <= cfg.data[LEN_W-1:0];
						sum_q        <= '0;
						fill_q       <= '0;
						slot_q       <= '0;
					end
					REG_MEAN_GAIN:     mean_gain_q     <= $signed(cfg.data[GAIN_W-1:0]);
					REG_MOMENTUM_GAIN: momentum_gain_q <= $signed(cfg.data[GAIN_W-1:0]);
					REG_TRIGGER_LEVEL: level_q         <= cfg.data[LEVEL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= sample.price;
			fwd_q   <= (fill_q == '0);
		end
		if (state_q == ST_READ) begin
			oldest_q <= oldest;
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			mean_q <= div_rsp.quotient[PRICE_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod0_q <= prod0;
			prod1_q <= prod1;
		end
		if (state_q == ST_SUM) begin
			score_q <= SCORE_W'(total >>> FRAC_DROP);
		end
		if (out_load) begin
			out_side_q  <= holding_q ? SIDE_SELL : SIDE_BUY;
			out_score_q <= score_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (trigger.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign trigger.valid = out_valid_q;
	assign trigger.side  = out_side_q;
	assign trigger.score = out_score_q;

	a_fill_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q < eff_len))
		else $error("window fill count reached the window length");

	a_flip_on_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (holding_q != $past(holding_q)))
		else $error("position flag did not flip with a trigger");

	a_side_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_side_q == !holding_q))
		else $error("trigger side disagrees with position flag");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the window-mean score trigger core.
`timescale 1ns / 1ps
module tb_top;
	import wmst_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE       = 64;    // longer than one full-window sample takes
	localparam int STUCK_LIMIT  = 6000;  // cycles with no item moved on any channel

	typedef struct packed {
		logic               side;
		logic signed [63:0] score;
	} trig_t;

	logic clk;
	logic arst_n;

	wmst_price_if px_if();
	wmst_cfg_if   cfg_if();
	wmst_trig_if  trig_if();

	window_mean_score_trigger_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (px_if),
		.cfg     (cfg_if),
		.trigger (trig_if)
	);

	// Shared testbench state
	logic [31:0] price_q[$];
	trig_t       trig_expect_q[$];
	bit          no_idle;
	int unsigned mismatch_count;
	int unsigned stuck_cycles;
	logic [31:0] walk_price;

	// Shadow of the block: registers, delay line, running sum, position
	logic [LEN_W-1:0]          len_reg;
	logic signed [GAIN_W-1:0]  mean_gain_r;
	logic signed [GAIN_W-1:0]  mom_gain_r;
	logic [LEVEL_W-1:0]        level_r;
	logic [PRICE_W-1:0]        hist_mem [MAX_WINDOW];
	logic [SUM_W-1:0]          win_sum;
	int unsigned               fill_n;
	logic [HIST_AW-1:0]        wr_slot;
	bit                        holding;

	always #CLK_HALF clk = ~clk;

	// Idle stretch: mostly a few cycles, now and then a long one
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Fold one price into the shadow state; returns 1 when a trigger is due
	function automatic bit predict_trigger(input logic [31:0] p, output trig_t t);
		int unsigned        w;
		int unsigned        cnt;
		logic [HIST_AW-1:0] slot;
		logic [HIST_AW-1:0] old_slot;
		logic [PRICE_W-1:0] oldest;
		logic [SUM_W-1:0]   mean;
		longint             d_mean;
		longint             d_mom;
		longint             acc;
		longint             sc;
		longint             lvl;
		t = '0;
		if (len_reg == 0)
			w = 1;
		else if (len_reg > MAX_WINDOW)
			w = MAX_WINDOW;
		else
			w = {18'd0, len_reg};
		slot = wr_slot;
		hist_mem[slot] = p;
		win_sum = win_sum + SUM_W'(p);
		cnt = fill_n + 1;
		wr_slot = slot + 1'b1;
		// still warming up
		if (cnt < w) begin
			fill_n = cnt;
			return 1'b0;
		end
		old_slot = slot - HIST_AW'(cnt - 1);
		oldest = hist_mem[old_slot];
		mean = win_sum / SUM_W'(w);
		win_sum = win_sum - SUM_W'(oldest);
		fill_n = cnt - 1;
		d_mean = longint'({32'd0, p}) - longint'({19'd0, mean});
		d_mom  = longint'({32'd0, p}) - longint'({32'd0, oldest});
		// exact products in 22 fraction bits, round half up to 8
		acc = longint'(mean_gain_r) * d_mean + longint'(mom_gain_r) * d_mom + 64'sd8192;
		sc = acc >>> FRAC_DROP;
		lvl = longint'({33'd0, level_r});
		if (!holding && sc > lvl) begin
			holding = 1'b1;
			t.side = SIDE_BUY;
			t.score = sc;
			return 1'b1;
		end
		if (holding && sc < -lvl) begin
			holding = 1'b0;
			t.side = SIDE_SELL;
			t.score = sc;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Price driver
	int unsigned gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_if.valid <= 1'b0;
			px_if.price <= '0;
			gap_left    <= 0;
		end else if (!(px_if.valid && !px_if.ready)) begin
			if (gap_left != 0) begin
				px_if.valid <= 1'b0;
				gap_left    <= gap_left - 1;
			end else if (price_q.size() != 0) begin
				px_if.valid <= 1'b1;
				px_if.price <= price_q.pop_front();
				gap_left    <= (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
			end else begin
				px_if.valid <= 1'b0;
			end
		end
	end

	// Trigger sink back-pressure
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_if.ready <= 1'b0;
			stall_left    <= 0;
		end else if (stall_left != 0) begin
			trig_if.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			trig_if.ready <= 1'b0;
			stall_left    <= idle_len() - 1;
		end else begin
			trig_if.ready <= 1'b1;
		end
	end

	// Monitor: shadow updates, trigger checks, progress watchdog
	always @(posedge clk) begin
		trig_t got;
		trig_t want;
		if (!arst_n) begin
			len_reg      = RST_WINDOW_LEN;
			mean_gain_r  = RST_MEAN_GAIN;
			mom_gain_r   = RST_MOMENTUM_GAIN;
			level_r      = RST_TRIGGER_LEVEL;
			win_sum      = '0;
			fill_n       = 0;
			wr_slot      = '0;
			holding      = 1'b0;
			stuck_cycles = 0;
		end else begin
			if (trig_if.valid && trig_if.ready) begin
				if (trig_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected trigger side %0d score %0d",
						trig_if.side, trig_if.score));
				end else begin
					want = trig_expect_q.pop_front();
					if (trig_if.side !== want.side)
						report_mismatch($sformatf("side %0d, expected %0d (score %0d)",
							trig_if.side, want.side, want.score));
					if (trig_if.score !== want.score)
						report_mismatch($sformatf("score %0d, expected %0d",
							trig_if.score, want.score));
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_WINDOW_LEN: begin
						len_reg = cfg_if.data[LEN_W-1:0];
						win_sum = '0;
						fill_n  = 0;
						wr_slot = '0;
					end
					REG_MEAN_GAIN:     mean_gain_r = cfg_if.data[GAIN_W-1:0];
					REG_MOMENTUM_GAIN: mom_gain_r  = cfg_if.data[GAIN_W-1:0];
					REG_TRIGGER_LEVEL: level_r     = cfg_if.data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (px_if.valid && px_if.ready) begin
				if (predict_trigger(px_if.price, got))
					trig_expect_q.push_back(got);
			end
			// watchdog
			if ((px_if.valid && px_if.ready) || (cfg_if.valid && cfg_if.ready) ||
					(trig_if.valid && trig_if.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d triggers due",
					STUCK_LIMIT, trig_expect_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// Wait until all queued prices are taken, optionally all triggers too
	task automatic wait_drain(input bit all_results);
		do @(negedge clk);
		while (price_q.size() != 0 || px_if.valid ||
			(all_results && trig_expect_q.size() != 0));
	endtask

	task automatic wait_idle();
		wait_drain(1'b1);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_window(input logic [LEN_W-1:0] len);
		logic [31:0] d;
		d = $urandom;
		d[LEN_W-1:0] = len;
		write_reg(REG_WINDOW_LEN, d);
	endtask

	task automatic set_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] g);
		logic [31:0] d;
		d = $urandom;
		d[GAIN_W-1:0] = g;
		write_reg(idx, d);
	endtask

	task automatic set_level(input logic [LEVEL_W-1:0] lvl);
		logic [31:0] d;
		d = $urandom;
		d[LEVEL_W-1:0] = lvl;
		write_reg(REG_TRIGGER_LEVEL, d);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return LEVEL_W'($urandom);
			default: return LEVEL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Random register settings, each register written or kept
	task automatic pick_settings();
		int unsigned r;
		if ($urandom_range(0, 1)) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				set_window(14'd0);
			else if (r == 1)
				set_window(14'd1);
			else if (r < 8)
				set_window(LEN_W'($urandom_range(2, 12)));
			else
				set_window(LEN_W'($urandom_range(13, 80)));
		end
		if ($urandom_range(0, 4) < 3)
			set_gain(REG_MEAN_GAIN, pick_gain());
		if ($urandom_range(0, 4) < 3)
			set_gain(REG_MOMENTUM_GAIN, pick_gain());
		if ($urandom_range(0, 4) < 3)
			set_level(pick_level());
	endtask

	// Trending prices with small steps, with rare spikes; or pure noise
	task automatic queue_prices(input int unsigned count, input bit trend);
		int unsigned step;
		for (int unsigned i = 0; i < count; i++) begin
			if (!trend || $urandom_range(0, 15) == 0) begin
				price_q.push_back($urandom);
			end else begin
				step = $urandom_range(0, 8191);
				walk_price = walk_price + step - 32'd4096;
				price_q.push_back(walk_price);
			end
		end
	endtask

	// Stimulus
	initial begin
		int unsigned fed;
		int unsigned n;
		int unsigned k;
		bit          trend;
		bit          first_pause;
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data  <= '0;
		no_idle = 1'b0;
		mismatch_count = 0;
		walk_price = $urandom;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window length zero acts as one: score stays zero, equals a zero level
		set_window(14'd0);
		set_level('0);
		price_q.push_back(32'h0000_0000);
		price_q.push_back(32'hFFFF_FFFF);
		price_q.push_back(32'h8000_0000);
		wait_idle();

		// extreme gains on full-scale swings
		set_window(14'd3);
		set_gain(REG_MEAN_GAIN, 16'h7FFF);
		set_gain(REG_MOMENTUM_GAIN, 16'h8000);
		for (int i = 0; i < 3; i++) begin
			price_q.push_back(32'h0000_0000);
			price_q.push_back(32'hFFFF_FFFF);
		end
		price_q.push_back(32'h8000_0000);
		price_q.push_back(32'h0000_0001);
		wait_idle();

		// opposite gain extremes against the largest level
		set_window(14'd2);
		set_gain(REG_MEAN_GAIN, 16'h8000);
		set_gain(REG_MOMENTUM_GAIN, 16'h7FFF);
		set_level(31'h7FFF_FFFF);
		price_q.push_back(32'h0000_0000);
		price_q.push_back(32'hFFFF_FFFF);
		price_q.push_back(32'h0000_0000);
		price_q.push_back(32'hFFFF_FFFF);
		price_q.push_back(32'h0000_0000);
		price_q.push_back(32'h7FFF_FFFF);
		wait_idle();

		// largest window, then a length beyond it that is clamped;
		// a short run that stays in warm-up
		for (int i = 0; i < 2; i++) begin
			set_window(i == 0 ? 14'd8192 : 14'h3FFF);
			set_gain(REG_MEAN_GAIN, GAIN_W'($urandom_range(0, 4000) - 2000));
			set_gain(REG_MOMENTUM_GAIN, GAIN_W'($urandom_range(0, 4000) - 2000));
			set_level(LEVEL_W'($urandom_range(0, 255)));
			no_idle = (i == 1);
			queue_prices(24, 1'b1);
			wait_idle();
		end

		// random phases
		fed = 0;
		first_pause = 1'b1;
		while (fed < 380) begin
			pick_settings();
			no_idle = ($urandom_range(0, 4) == 0);
			trend = ($urandom_range(0, 9) < 7);
			if ($urandom_range(0, 3) == 0)
				walk_price = $urandom;
			n = $urandom_range(15, 45);
			fed += n;
			while (n != 0) begin
				k = $urandom_range(3, 12);
				if (k > n)
					k = n;
				n -= k;
				queue_prices(k, trend);
				// sender holds until its prices are taken, and at times until every due trigger is out
				wait_drain(first_pause || $urandom_range(0, 3) == 0);
				first_pause = 1'b0;
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
